>>> src/dsf_pkg.sv
package dsf_pkg;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ABSORPTION = 1'b1;

  localparam logic [31:0] STIFFNESS_RST  = 32'h0001_0000;
  localparam logic [31:0] ABSORPTION_RST = 32'h0000_0000;

  // q16.16 limits and the nudge applied to coincident points
  localparam logic signed [31:0] Q_MAX       = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] NUDGE_STEP  = 32'sd13;
  localparam logic [6:0]         NEAR_DIST_SQ = 7'd49;

  // square root unit: 63-bit radicand, one result bit per stage
  localparam int SQ_IN_W  = 63;
  localparam int ROOT_W   = 32;
  localparam int SQRT_LAT = ROOT_W;

  // divider for the unit axis: |d| * 2^16 / dist, quotient at most 2^16
  localparam int NUM_W   = 49;
  localparam int DEN_W   = 33;
  localparam int QUO_W   = 17;
  localparam int DIV_LAT = QUO_W;

  // five front stages, square root, distance, divider, axis, nine back stages
  localparam int LATENCY = 5 + SQRT_LAT + 1 + DIV_LAT + 1 + 9;

  typedef struct packed {
    logic               func;
    logic signed [31:0] pos1_x;
    logic signed [31:0] pos1_y;
    logic signed [31:0] pos2_x;
    logic signed [31:0] pos2_y;
    logic signed [31:0] vel1_x;
    logic signed [31:0] vel1_y;
    logic signed [31:0] vel2_x;
    logic signed [31:0] vel2_y;
    logic [30:0]        rest_length;
    logic signed [31:0] fixed_x;
    logic signed [31:0] fixed_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_delta_x;
    logic signed [31:0] force_delta_y;
    logic signed [31:0] pos2_y_out;
    logic               nudged;
    logic               saturated;
  } out_t;

endpackage

>>> src/dsf_sqrt.sv
module dsf_sqrt (
  input  logic                       clk,
  input  logic [dsf_pkg::SQ_IN_W-1:0] radicand,
  output logic [dsf_pkg::ROOT_W-1:0]  root
);
  import dsf_pkg::*;

  logic [63:0] x_q [SQRT_LAT];
  logic [63:0] r_q [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    localparam int K = SQRT_LAT - 1 - i;
    localparam logic [63:0] Bit = 64'(1) << (2 * K);
    logic [63:0] xi;
    logic [63:0] ri;
    logic [63:0] trial;

    if (i == 0) begin : g_first
      assign xi = 64'(radicand);
      assign ri = '0;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign ri = r_q[i-1];
    end

    assign trial = ri + Bit;

    always_ff @(posedge clk) begin
      if (xi >= trial) begin
        x_q[i] <= xi - trial;
        r_q[i] <= (ri >> 1) + Bit;
      end else begin
        x_q[i] <= xi;
        r_q[i] <= ri >> 1;
      end
    end
  end

  assign root = r_q[SQRT_LAT-1][ROOT_W-1:0];

endmodule

>>> src/dsf_div.sv
module dsf_div (
  input  logic                      clk,
  input  logic [dsf_pkg::NUM_W-1:0] num,
  input  logic [dsf_pkg::DEN_W-1:0] den,
  output logic [dsf_pkg::QUO_W-1:0] quo
);
  import dsf_pkg::*;

  logic [NUM_W-1:0] rem_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [QUO_W-1:0] quo_q [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    localparam int K = DIV_LAT - 1 - i;
    logic [NUM_W-1:0] rin;
    logic [DEN_W-1:0] din;
    logic [QUO_W-1:0] qin;
    logic [NUM_W:0]   dsh;

    if (i == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign din = den_q[i-1];
      assign qin = quo_q[i-1];
    end

    assign dsh = (NUM_W + 1)'(din) << K;

    always_ff @(posedge clk) begin
      den_q[i] <= din;
      if ({1'b0, rin} >= dsh) begin
        rem_q[i] <= rin - dsh[NUM_W-1:0];
        quo_q[i] <= qin | (QUO_W'(1) << K);
      end else begin
        rem_q[i] <= rin;
        quo_q[i] <= qin;
      end
    end
  end

  assign quo = quo_q[DIV_LAT-1];

endmodule

>>> src/damped_spring_force_unit.sv
// Damped 2D spring force, Q16.16. One spring item is taken on every clock
// edge with start high; busy stays low because the pipeline never stalls.
// Each item produces exactly one result beat, shown on result with done
// high for one cycle, in input order. The pipeline holds a 32-stage
// square root (one root bit per stage), two 17-stage restoring dividers
// for the unit axis, and split 17x32 multiplies for stiffness and
// absorption. stiffness and absorption are written through
// cfg_we/cfg_index/cfg_data and take effect on items taken after the
// write; change them only while no item is in flight.
module damped_spring_force_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  dsf_pkg::in_t                   item,
  input  logic                           cfg_we,
  input  logic [dsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           done,
  output dsf_pkg::out_t                  result
);
  import dsf_pkg::*;

  // everything that rides alongside the square root and the dividers
  typedef struct packed {
    logic               func;
    logic signed [33:0] base_x;   // dx, or dx - fixed_x in fixed vector mode
    logic signed [33:0] base_y;
    logic signed [32:0] vx;       // relative velocity vel1 - vel2
    logic signed [32:0] vy;
    logic [30:0]        rest;
    logic signed [31:0] p2y_out;
    logic               nudged;
    logic [32:0]        amag_x;   // |dx|, |dy| after the nudge
    logic [32:0]        amag_y;
    logic               neg_x;
    logic               neg_y;
    logic               shr;      // distance taken on halved magnitudes
  } side_t;

  // small-distance test: true when dx^2 + dy^2 < 49
  function automatic logic is_near(input logic signed [32:0] a,
                                   input logic signed [32:0] b);
    logic       small_a;
    logic       small_b;
    logic [2:0] ma;
    logic [2:0] mb;
    logic [6:0] ss;
    small_a = (a >= -33'sd6) && (a <= 33'sd6);
    small_b = (b >= -33'sd6) && (b <= 33'sd6);
    ma = a[32] ? 3'(4'(~a[3:0]) + 4'd1) : a[2:0];
    mb = b[32] ? 3'(4'(~b[3:0]) + 4'd1) : b[2:0];
    ss = 7'(ma) * 7'(ma) + 7'(mb) * 7'(mb);
    return small_a && small_b && (ss < NEAR_DIST_SQ);
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] stiffness;
  logic [31:0] absorption;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness  <= STIFFNESS_RST;
      absorption <= ABSORPTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STIFFNESS:  stiffness  <= cfg_data;
        REG_ABSORPTION: absorption <= cfg_data;
        default: ;
      endcase
    end
  end

  // no stall anywhere, so every start beat is taken
  assign busy = 1'b0;

  // valid bits, one per pipeline register stage
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start};
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: raw differences, nudged y candidate
  // ---------------------------------------------------------------------
  logic               s1_func;
  logic signed [32:0] s1_dx;
  logic signed [32:0] s1_dy0;
  logic signed [31:0] s1_p2yn;
  logic signed [31:0] s1_p2y;
  logic signed [31:0] s1_p1y;
  logic signed [32:0] s1_vx;
  logic signed [32:0] s1_vy;
  logic [30:0]        s1_rest;
  logic signed [31:0] s1_fx;
  logic signed [31:0] s1_fy;
  logic signed [32:0] p2y_inc;

  assign p2y_inc = 33'(item.pos2_y) + 33'(NUDGE_STEP);

  always_ff @(posedge clk) begin
    s1_func <= item.func;
    s1_dx   <= 33'(item.pos2_x) - 33'(item.pos1_x);
    s1_dy0  <= 33'(item.pos2_y) - 33'(item.pos1_y);
    // nudge saturates at the top of the range
    s1_p2yn <= (p2y_inc > 33'(Q_MAX)) ? Q_MAX : p2y_inc[31:0];
    s1_p2y  <= item.pos2_y;
    s1_p1y  <= item.pos1_y;
    s1_vx   <= 33'(item.vel1_x) - 33'(item.vel2_x);
    s1_vy   <= 33'(item.vel1_y) - 33'(item.vel2_y);
    s1_rest <= item.rest_length;
    s1_fx   <= item.fixed_x;
    s1_fy   <= item.fixed_y;
  end

  // ---------------------------------------------------------------------
  // stage 2: coincident-point check and nudge
  // ---------------------------------------------------------------------
  logic               s2_func;
  logic signed [32:0] s2_dx;
  logic signed [32:0] s2_dy0;
  logic signed [32:0] s2_dy;
  logic signed [31:0] s2_p2y_out;
  logic               s2_nudged;
  logic signed [32:0] s2_vx;
  logic signed [32:0] s2_vy;
  logic [30:0]        s2_rest;
  logic signed [31:0] s2_fx;
  logic signed [31:0] s2_fy;
  logic               near;
  logic signed [32:0] dy_nudged;

  assign near      = is_near(s1_dx, s1_dy0);
  assign dy_nudged = 33'(s1_p2yn) - 33'(s1_p1y);

  always_ff @(posedge clk) begin
    s2_func    <= s1_func;
    s2_dx      <= s1_dx;
    s2_dy0     <= s1_dy0;
    s2_dy      <= near ? dy_nudged : s1_dy0;
    s2_p2y_out <= near ? s1_p2yn : s1_p2y;
    s2_nudged  <= near;
    s2_vx      <= s1_vx;
    s2_vy      <= s1_vy;
    s2_rest    <= s1_rest;
    s2_fx      <= s1_fx;
    s2_fy      <= s1_fy;
  end

  // ---------------------------------------------------------------------
  // stage 3: magnitudes, range halving, spring base offsets
  // ---------------------------------------------------------------------
  side_t       s3_side;
  logic [30:0] s3_hx;
  logic [30:0] s3_hy;
  logic [32:0] amx;
  logic [32:0] amy;
  logic        shr;

  assign amx = s2_dx[32] ? 33'(-s2_dx) : 33'(s2_dx);
  assign amy = s2_dy[32] ? 33'(-s2_dy) : 33'(s2_dy);
  // halve both when either magnitude reaches 2^31
  assign shr = amx[32] | amx[31] | amy[32] | amy[31];

  always_ff @(posedge clk) begin
    s3_side.func    <= s2_func;
    // fixed vector mode works on the offset before the nudge
    s3_side.base_x  <= s2_func ? 34'(s2_dx) - 34'(s2_fx) : 34'(s2_dx);
    s3_side.base_y  <= s2_func ? 34'(s2_dy0) - 34'(s2_fy) : 34'(s2_dy);
    s3_side.vx      <= s2_vx;
    s3_side.vy      <= s2_vy;
    s3_side.rest    <= s2_rest;
    s3_side.p2y_out <= s2_p2y_out;
    s3_side.nudged  <= s2_nudged;
    s3_side.amag_x  <= amx;
    s3_side.amag_y  <= amy;
    s3_side.neg_x   <= s2_dx[32];
    s3_side.neg_y   <= s2_dy[32];
    s3_side.shr     <= shr;
    s3_hx           <= shr ? amx[31:1] : amx[30:0];
    s3_hy           <= shr ? amy[31:1] : amy[30:0];
  end

  // ---------------------------------------------------------------------
  // stages 4 and 5: squares and their sum
  // ---------------------------------------------------------------------
  side_t               s4_side;
  logic [61:0]         s4_px;
  logic [61:0]         s4_py;
  side_t               s5_side;
  logic [SQ_IN_W-1:0]  s5_sum;

  always_ff @(posedge clk) begin
    s4_side <= s3_side;
    s4_px   <= 62'(s3_hx) * 62'(s3_hx);
    s4_py   <= 62'(s3_hy) * 62'(s3_hy);
    s5_side <= s4_side;
    s5_sum  <= SQ_IN_W'(s4_px) + SQ_IN_W'(s4_py);
  end

  // ---------------------------------------------------------------------
  // square root, side data follows in a matching delay line
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] root;
  side_t             sq_side [SQRT_LAT];

  dsf_sqrt u_sqrt (
    .clk      (clk),
    .radicand (s5_sum),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    sq_side[0] <= s5_side;
    for (int i = 1; i < SQRT_LAT; i++) begin
      sq_side[i] <= sq_side[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // distance and divider operands
  // ---------------------------------------------------------------------
  side_t            ds_side;
  logic [DEN_W-1:0] ds_den;
  logic [NUM_W-1:0] ds_num_x;
  logic [NUM_W-1:0] ds_num_y;

  always_ff @(posedge clk) begin
    ds_side  <= sq_side[SQRT_LAT-1];
    // zero distance only when both offsets are zero: a unit divisor then
    // gives the zero axis
    if (root == '0) begin
      ds_den <= DEN_W'(1);
    end else if (sq_side[SQRT_LAT-1].shr) begin
      ds_den <= {root, 1'b0};
    end else begin
      ds_den <= {1'b0, root};
    end
    ds_num_x <= {sq_side[SQRT_LAT-1].amag_x, 16'h0000};
    ds_num_y <= {sq_side[SQRT_LAT-1].amag_y, 16'h0000};
  end

  // ---------------------------------------------------------------------
  // unit axis magnitudes, one quotient bit per stage
  // ---------------------------------------------------------------------
  logic [QUO_W-1:0] quo_x;
  logic [QUO_W-1:0] quo_y;
  side_t            dv_side [DIV_LAT];

  dsf_div u_div_x (
    .clk (clk),
    .num (ds_num_x),
    .den (ds_den),
    .quo (quo_x)
  );

  dsf_div u_div_y (
    .clk (clk),
    .num (ds_num_y),
    .den (ds_den),
    .quo (quo_y)
  );

  always_ff @(posedge clk) begin
    dv_side[0] <= ds_side;
    for (int i = 1; i < DIV_LAT; i++) begin
      dv_side[i] <= dv_side[i-1];
    end
  end

  // signed unit axis, truncated toward zero
  side_t              n_side;
  logic [QUO_W-1:0]   n_mag_x;
  logic [QUO_W-1:0]   n_mag_y;
  logic signed [17:0] n_x;
  logic signed [17:0] n_y;

  always_ff @(posedge clk) begin
    n_side  <= dv_side[DIV_LAT-1];
    n_mag_x <= quo_x;
    n_mag_y <= quo_y;
    n_x     <= dv_side[DIV_LAT-1].neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    n_y     <= dv_side[DIV_LAT-1].neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
  end

  // ---------------------------------------------------------------------
  // p1: rest offset products and velocity projection products
  // ---------------------------------------------------------------------
  side_t              p1_side;
  logic signed [17:0] p1_nx;
  logic signed [17:0] p1_ny;
  logic [46:0]        p1_rp_x;
  logic [46:0]        p1_rp_y;
  logic signed [50:0] p1_dp_x;
  logic signed [50:0] p1_dp_y;

  always_ff @(posedge clk) begin
    p1_side <= n_side;
    p1_nx   <= n_x;
    p1_ny   <= n_y;
    // |n| <= 2^16 and rest < 2^31, so the product stays below 2^47
    p1_rp_x <= 47'(n_mag_x) * 47'(n_side.rest);
    p1_rp_y <= 47'(n_mag_y) * 47'(n_side.rest);
    p1_dp_x <= 51'(n_side.vx) * 51'(n_x);
    p1_dp_y <= 51'(n_side.vy) * 51'(n_y);
  end

  // ---------------------------------------------------------------------
  // p2: spring offsets and projection sum
  // ---------------------------------------------------------------------
  side_t              p2_side;
  logic signed [17:0] p2_nx;
  logic signed [17:0] p2_ny;
  logic signed [33:0] p2_off_x;
  logic signed [33:0] p2_off_y;
  logic signed [51:0] p2_dsum;
  logic signed [33:0] roff_x;
  logic signed [33:0] roff_y;

  // rest offset magnitude, moved toward the first point along the axis
  assign roff_x = $signed(34'(p1_rp_x[46:16]));
  assign roff_y = $signed(34'(p1_rp_y[46:16]));

  always_ff @(posedge clk) begin
    p2_side <= p1_side;
    p2_nx   <= p1_nx;
    p2_ny   <= p1_ny;
    if (p1_side.func) begin
      p2_off_x <= p1_side.base_x;
      p2_off_y <= p1_side.base_y;
    end else begin
      p2_off_x <= p1_side.base_x + (p1_side.neg_x ? roff_x : -roff_x);
      p2_off_y <= p1_side.base_y + (p1_side.neg_y ? roff_y : -roff_y);
    end
    p2_dsum <= 52'(p1_dp_x) + 52'(p1_dp_y);
  end

  // ---------------------------------------------------------------------
  // p3: projection rescale, offset magnitudes
  // ---------------------------------------------------------------------
  side_t              p3_side;
  logic signed [17:0] p3_nx;
  logic signed [17:0] p3_ny;
  logic signed [34:0] p3_dot;
  logic [33:0]        p3_omag_x;
  logic [33:0]        p3_omag_y;
  logic               p3_oneg_x;
  logic               p3_oneg_y;
  logic signed [51:0] dsum_adj;

  // bias negatives so the shift truncates toward zero
  assign dsum_adj = p2_dsum + (p2_dsum[51] ? 52'sd65535 : 52'sd0);

  always_ff @(posedge clk) begin
    p3_side   <= p2_side;
    p3_nx     <= p2_nx;
    p3_ny     <= p2_ny;
    p3_dot    <= dsum_adj[50:16];
    p3_omag_x <= p2_off_x[33] ? 34'(-p2_off_x) : 34'(p2_off_x);
    p3_omag_y <= p2_off_y[33] ? 34'(-p2_off_y) : 34'(p2_off_y);
    p3_oneg_x <= p2_off_x[33];
    p3_oneg_y <= p2_off_y[33];
  end

  // ---------------------------------------------------------------------
  // p4: axis products and spring partial products
  // ---------------------------------------------------------------------
  side_t              p4_side;
  logic signed [52:0] p4_ap_x;
  logic signed [52:0] p4_ap_y;
  logic [48:0]        p4_sh_x;
  logic [48:0]        p4_sl_x;
  logic [48:0]        p4_sh_y;
  logic [48:0]        p4_sl_y;
  logic               p4_oneg_x;
  logic               p4_oneg_y;

  always_ff @(posedge clk) begin
    p4_side   <= p3_side;
    p4_ap_x   <= 53'(p3_dot) * 53'(p3_nx);
    p4_ap_y   <= 53'(p3_dot) * 53'(p3_ny);
    p4_sh_x   <= 49'(p3_omag_x[33:17]) * 49'(stiffness);
    p4_sl_x   <= 49'(p3_omag_x[16:0]) * 49'(stiffness);
    p4_sh_y   <= 49'(p3_omag_y[33:17]) * 49'(stiffness);
    p4_sl_y   <= 49'(p3_omag_y[16:0]) * 49'(stiffness);
    p4_oneg_x <= p3_oneg_x;
    p4_oneg_y <= p3_oneg_y;
  end

  // ---------------------------------------------------------------------
  // p5: axis rescale, spring term = offset * stiffness / 2^17
  // ---------------------------------------------------------------------
  side_t              p5_side;
  logic signed [34:0] p5_axis_x;
  logic signed [34:0] p5_axis_y;
  logic signed [50:0] p5_spring_x;
  logic signed [50:0] p5_spring_y;
  logic signed [52:0] ap_adj_x;
  logic signed [52:0] ap_adj_y;
  logic [49:0]        smag_x;
  logic [49:0]        smag_y;

  assign ap_adj_x = p4_ap_x + (p4_ap_x[52] ? 53'sd65535 : 53'sd0);
  assign ap_adj_y = p4_ap_y + (p4_ap_y[52] ? 53'sd65535 : 53'sd0);
  // high partial lands already scaled, only the low partial is shifted
  assign smag_x   = 50'(p4_sh_x) + 50'(p4_sl_x[48:17]);
  assign smag_y   = 50'(p4_sh_y) + 50'(p4_sl_y[48:17]);

  always_ff @(posedge clk) begin
    p5_side     <= p4_side;
    p5_axis_x   <= ap_adj_x[50:16];
    p5_axis_y   <= ap_adj_y[50:16];
    p5_spring_x <= p4_oneg_x ? -$signed({1'b0, smag_x}) : $signed({1'b0, smag_x});
    p5_spring_y <= p4_oneg_y ? -$signed({1'b0, smag_y}) : $signed({1'b0, smag_y});
  end

  // ---------------------------------------------------------------------
  // p6: axis magnitudes
  // ---------------------------------------------------------------------
  side_t              p6_side;
  logic [33:0]        p6_amag_x;
  logic [33:0]        p6_amag_y;
  logic               p6_aneg_x;
  logic               p6_aneg_y;
  logic signed [50:0] p6_spring_x;
  logic signed [50:0] p6_spring_y;

  always_ff @(posedge clk) begin
    p6_side     <= p5_side;
    p6_amag_x   <= p5_axis_x[34] ? 34'(-p5_axis_x) : 34'(p5_axis_x);
    p6_amag_y   <= p5_axis_y[34] ? 34'(-p5_axis_y) : 34'(p5_axis_y);
    p6_aneg_x   <= p5_axis_x[34];
    p6_aneg_y   <= p5_axis_y[34];
    p6_spring_x <= p5_spring_x;
    p6_spring_y <= p5_spring_y;
  end

  // ---------------------------------------------------------------------
  // p7: damping partial products
  // ---------------------------------------------------------------------
  side_t              p7_side;
  logic [48:0]        p7_dh_x;
  logic [48:0]        p7_dl_x;
  logic [48:0]        p7_dh_y;
  logic [48:0]        p7_dl_y;
  logic               p7_aneg_x;
  logic               p7_aneg_y;
  logic signed [50:0] p7_spring_x;
  logic signed [50:0] p7_spring_y;

  always_ff @(posedge clk) begin
    p7_side     <= p6_side;
    p7_dh_x     <= 49'(p6_amag_x[33:17]) * 49'(absorption);
    p7_dl_x     <= 49'(p6_amag_x[16:0]) * 49'(absorption);
    p7_dh_y     <= 49'(p6_amag_y[33:17]) * 49'(absorption);
    p7_dl_y     <= 49'(p6_amag_y[16:0]) * 49'(absorption);
    p7_aneg_x   <= p6_aneg_x;
    p7_aneg_y   <= p6_aneg_y;
    p7_spring_x <= p6_spring_x;
    p7_spring_y <= p6_spring_y;
  end

  // ---------------------------------------------------------------------
  // p8: damping term = axis * absorption / 2^16
  // ---------------------------------------------------------------------
  side_t              p8_side;
  logic signed [51:0] p8_damp_x;
  logic signed [51:0] p8_damp_y;
  logic signed [50:0] p8_spring_x;
  logic signed [50:0] p8_spring_y;
  logic [50:0]        dmag_x;
  logic [50:0]        dmag_y;

  assign dmag_x = 51'({p7_dh_x, 1'b0}) + 51'(p7_dl_x[48:16]);
  assign dmag_y = 51'({p7_dh_y, 1'b0}) + 51'(p7_dl_y[48:16]);

  always_ff @(posedge clk) begin
    p8_side     <= p7_side;
    p8_damp_x   <= p7_aneg_x ? -$signed({1'b0, dmag_x}) : $signed({1'b0, dmag_x});
    p8_damp_y   <= p7_aneg_y ? -$signed({1'b0, dmag_y}) : $signed({1'b0, dmag_y});
    p8_spring_x <= p7_spring_x;
    p8_spring_y <= p7_spring_y;
  end

  // ---------------------------------------------------------------------
  // p9: force = spring - damping, clamped to 32 bits, result beat
  // ---------------------------------------------------------------------
  logic signed [52:0] frc_x;
  logic signed [52:0] frc_y;
  logic               hi_x;
  logic               lo_x;
  logic               hi_y;
  logic               lo_y;
  out_t               res_q;

  assign frc_x = 53'(p8_spring_x) - 53'(p8_damp_x);
  assign frc_y = 53'(p8_spring_y) - 53'(p8_damp_y);
  assign hi_x  = frc_x > 53'(Q_MAX);
  assign lo_x  = frc_x < 53'(Q_MIN);
  assign hi_y  = frc_y > 53'(Q_MAX);
  assign lo_y  = frc_y < 53'(Q_MIN);

  always_ff @(posedge clk) begin
    res_q.force_delta_x <= hi_x ? Q_MAX : (lo_x ? Q_MIN : frc_x[31:0]);
    res_q.force_delta_y <= hi_y ? Q_MAX : (lo_y ? Q_MIN : frc_y[31:0]);
    res_q.pos2_y_out    <= p8_side.p2y_out;
    res_q.nudged        <= p8_side.nudged;
    res_q.saturated     <= hi_x | lo_x | hi_y | lo_y;
  end

  assign result = res_q;
  assign done   = vld[LATENCY-1];

endmodule

>>> src/dsf_checker.sv
module dsf_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input dsf_pkg::in_t  item,
  input logic          done,
  input dsf_pkg::out_t result
);
  import dsf_pkg::*;

  // every taken item comes out after the fixed latency
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("taken item produced no result beat");

  // no result beat without an item taken earlier
  a_beat_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result beat without a source item");

  // without a nudge the second point's y passes through
  a_pos_kept: assert property (@(posedge clk) disable iff (rst)
    (done && !result.nudged) |-> (result.pos2_y_out == $past(item.pos2_y, LATENCY)))
    else $error("pos2_y changed without a nudge");

  // a nudge moves y, unless it sits at the top of the range
  a_pos_moved: assert property (@(posedge clk) disable iff (rst)
    (done && result.nudged) |->
      ((result.pos2_y_out != $past(item.pos2_y, LATENCY)) || (result.pos2_y_out == Q_MAX)))
    else $error("nudge left pos2_y unchanged");

  // a clamp leaves at least one component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (done && result.saturated) |->
      ((result.force_delta_x == Q_MAX) || (result.force_delta_x == Q_MIN) ||
       (result.force_delta_y == Q_MAX) || (result.force_delta_y == Q_MIN)))
    else $error("saturated flag without a clamped force");

endmodule

bind damped_spring_force_unit dsf_checker u_dsf_checker (.*);
